/* rtl/cmsc_pkg.sv */
`timescale 1ns / 1ps

package cmsc_pkg;

    localparam int DIV_W = 64;
    localparam int SHIFT_LIMIT_DEF = 32;

    localparam logic [DIV_W-1:0] NS_PER_SEC = 64'd1000000000;
    localparam logic [5:0] INV_EXTRA_MAX = 6'd32;
    localparam logic [6:0] TOT_SHIFT_CAP = 7'd64;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_HZ_ZERO   = 2'd1,
        ST_SPAN_ZERO = 2'd2,
        ST_BAD       = 2'd3
    } t_status;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

endpackage

/* rtl/cmsc_div.sv */
`timescale 1ns / 1ps

module cmsc_div
    import cmsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quot;
    logic [DIV_W-1:0] r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DIV_W:0]   n_rem_sh;
    logic [DIV_W:0]   n_rem_sub;
    logic             n_ge;

    // one quotient bit per cycle, restoring form
    always_comb begin
        n_rem_sh  = {r_rem, r_quot[DIV_W-1]};
        n_ge      = (n_rem_sh >= {1'b0, r_div});
        n_rem_sub = n_rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_rem  <= '0;
                r_quot <= i_req.dividend;
                r_div  <= i_req.divisor;
                r_cnt  <= CNT_W'(DIV_W - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= n_ge ? n_rem_sub[DIV_W-1:0] : n_rem_sh[DIV_W-1:0];
                r_quot <= {r_quot[DIV_W-2:0], n_ge};
                r_cnt  <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* rtl/clock_mult_shift_calc_top.sv */
`timescale 1ns / 1ps
// When the frequency is zero the error word is registered in the cycle after start;
// otherwise the sequencer runs its divisions on the shared 64-bit restoring divider,
// and an item needs up to 33 forward and 32 inverse divisions.
// Throughput: one word at a time; busy stays high until the result strobe.
// The receiver cannot stall: each result shows for one cycle under o_valid.
// Reset: synchronous, active low; the sequencer and divider return to idle.

module clock_mult_shift_calc_top
    import cmsc_pkg::*;
#(
    parameter int SHIFT_LIMIT = SHIFT_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_clock_hz,
    input  logic [31:0] i_span_seconds,
    output logic        o_valid,
    output logic [31:0] o_fwd_mult,
    output logic [5:0]  o_fwd_shift,
    output logic [31:0] o_inv_mult,
    output logic [6:0]  o_inv_shift,
    output logic [1:0]  o_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FWD_START,
        S_FWD_WAIT,
        S_INV_START,
        S_INV_WAIT,
        S_FINISH
    } t_state;

    t_state         r_state;
    logic [63:0]    r_hz;
    logic           r_span_zero;
    logic [5:0]     r_sh;
    logic [31:0]    r_prev_q;
    logic [31:0]    r_mult;
    logic [5:0]     r_shift;
    logic [5:0]     r_extra;
    logic [31:0]    r_imult;
    logic [6:0]     r_ishift;
    t_status        r_status;
    logic           r_valid;

    t_div_req       div_req;
    logic           div_done;
    logic [63:0]    div_quot;

    logic [6:0]     tot_shift;
    logic [5:0]     fwd_shift_sel;
    logic [31:0]    fwd_mult_sel;

    assign tot_shift = {1'b0, r_shift} + {1'b0, r_extra};

    // back off one step if the first nonzero multiplier overflows 32 bits and the shift is not zero
    always_comb begin
        fwd_shift_sel = r_sh;
        fwd_mult_sel  = div_quot[31:0];
        if (div_quot[63:32] != '0 && r_sh != '0) begin
            fwd_shift_sel = r_sh - 6'd1;
            fwd_mult_sel  = r_prev_q;
        end
    end

    always_comb begin
        div_req.start    = (r_state == S_FWD_START) ||
                           (r_state == S_INV_START && tot_shift < TOT_SHIFT_CAP);
        div_req.dividend = (r_state == S_FWD_START) ? (NS_PER_SEC << r_sh)
                                                    : (64'd1 << tot_shift[5:0]);
        div_req.divisor  = (r_state == S_FWD_START) ? r_hz : {32'd0, r_mult};
    end

    cmsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_hz        <= i_clock_hz;
                        r_span_zero <= (i_span_seconds == '0);
                        r_sh        <= '0;
                        r_prev_q    <= '0;
                        if (i_clock_hz == '0) begin
                            r_mult   <= '0;
                            r_shift  <= '0;
                            r_imult  <= '0;
                            r_ishift <= '0;
                            r_status <= ST_HZ_ZERO;
                            r_valid  <= 1'b1;
                        end else begin
                            r_state <= S_FWD_START;
                        end
                    end
                end
                S_FWD_START: begin
                    r_state <= S_FWD_WAIT;
                end
                S_FWD_WAIT: begin
                    if (div_done) begin
                        r_prev_q <= div_quot[31:0];
                        if (div_quot == '0) begin
                            if (r_sh == 6'(SHIFT_LIMIT)) begin
                                // no usable multiplier: skip the inverse
                                r_mult   <= '0;
                                r_shift  <= r_sh;
                                r_imult  <= '0;
                                r_ishift <= {1'b0, r_sh};
                                r_state  <= S_FINISH;
                            end else begin
                                r_sh    <= r_sh + 6'd1;
                                r_state <= S_FWD_START;
                            end
                        end else begin
                            r_mult   <= fwd_mult_sel;
                            r_shift  <= fwd_shift_sel;
                            r_imult  <= '0;
                            r_ishift <= {1'b0, fwd_shift_sel};
                            r_extra  <= INV_EXTRA_MAX;
                            r_state  <= (fwd_mult_sel == '0) ? S_FINISH : S_INV_START;
                        end
                    end
                end
                S_INV_START: begin
                    if (tot_shift < TOT_SHIFT_CAP) begin
                        r_state <= S_INV_WAIT;
                    end else if (r_extra == 6'd1) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_extra <= r_extra - 6'd1;
                    end
                end
                S_INV_WAIT: begin
                    if (div_done) begin
                        if (div_quot[63:32] == '0) begin
                            r_imult  <= div_quot[31:0];
                            r_ishift <= tot_shift;
                            r_state  <= S_FINISH;
                        end else if (r_extra == 6'd1) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_extra <= r_extra - 6'd1;
                            r_state <= S_INV_START;
                        end
                    end
                end
                S_FINISH: begin
                    if (r_span_zero) begin
                        r_status <= ST_SPAN_ZERO;
                    end else if (r_mult == '0 || r_imult == '0) begin
                        r_status <= ST_BAD;
                    end else begin
                        r_status <= ST_OK;
                    end
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_fwd_mult  = r_mult;
    assign o_fwd_shift = r_shift;
    assign o_inv_mult  = r_imult;
    assign o_inv_shift = r_ishift;
    assign o_status    = r_status;

    a_hz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_clock_hz == '0) |=> (o_valid && o_status == ST_HZ_ZERO))
        else $error("zero frequency did not give an immediate error word");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fwd_shift <= 6'(SHIFT_LIMIT)))
        else $error("forward shift beyond limit");

    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OK) |-> (o_fwd_mult != '0 && o_inv_mult != '0))
        else $error("ok status with zero multiplier");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_FWD_WAIT || r_state == S_INV_WAIT))
        else $error("divider finished outside a wait state");

endmodule

/* bench/clock_mult_shift_calc_top_test.sv */
`timescale 1ns / 1ps

module clock_mult_shift_calc_top_test;
    import cmsc_pkg::*;

    localparam int  CALC_SHIFT_LIMIT = SHIFT_LIMIT_DEF;
    localparam int  CYCLE_LIMIT      = 4_000_000;
    localparam int  RANDOM_WORDS     = 100;
    localparam int  CALM_TAIL        = 20;
    localparam int  DRAIN_CYCLES     = 50;

    typedef struct packed {
        logic [31:0] fwd_mult;
        logic [5:0]  fwd_shift;
        logic [31:0] inv_mult;
        logic [6:0]  inv_shift;
        t_status     status;
    } t_params;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [63:0] i_clock_hz;
    logic [31:0] i_span_seconds;
    logic        o_valid;
    logic [31:0] o_fwd_mult;
    logic [5:0]  o_fwd_shift;
    logic [31:0] o_inv_mult;
    logic [6:0]  o_inv_shift;
    logic [1:0]  o_status;

    t_params     params_due[$];
    t_params     due_word;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          sender_pauses = 1'b1;

    clock_mult_shift_calc_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_clock_hz     (i_clock_hz),
        .i_span_seconds (i_span_seconds),
        .o_valid        (o_valid),
        .o_fwd_mult     (o_fwd_mult),
        .o_fwd_shift    (o_fwd_shift),
        .o_inv_mult     (o_inv_mult),
        .o_inv_shift    (o_inv_shift),
        .o_status       (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_params calc_params(input logic [63:0] hz, input logic [31:0] span);
        t_params     p;
        logic [63:0] q;
        int          sh;
        int          chosen;
        int          n;
        bit          found;
        p        = '0;
        p.status = ST_HZ_ZERO;
        if (hz == 64'd0) begin
            return p;
        end
        // smallest shift with a nonzero multiplier, backing off if it overflows 32 bits
        chosen = CALC_SHIFT_LIMIT;
        found  = 1'b0;
        for (sh = 0; sh <= CALC_SHIFT_LIMIT; sh++) begin
            if (!found) begin
                q = (NS_PER_SEC << sh) / hz;
                if (q != 64'd0) begin
                    found  = 1'b1;
                    chosen = (q > 64'hFFFF_FFFF) ? ((sh > 0) ? sh - 1 : 0) : sh;
                end
            end
        end
        q           = (NS_PER_SEC << chosen) / hz;
        p.fwd_mult  = q[31:0];
        p.fwd_shift = chosen[5:0];
        p.inv_mult  = 32'd0;
        p.inv_shift = chosen[6:0];
        found       = 1'b0;
        if (p.fwd_mult != 32'd0) begin
            for (n = chosen + 32; n > chosen; n--) begin
                if (!found && n < 64) begin
                    q = (64'd1 << n) / {32'd0, p.fwd_mult};
                    if (q <= 64'hFFFF_FFFF) begin
                        found       = 1'b1;
                        p.inv_mult  = q[31:0];
                        p.inv_shift = n[6:0];
                    end
                end
            end
        end
        if (span == 32'd0) begin
            p.status = ST_SPAN_ZERO;
        end else if (p.fwd_mult == 32'd0 || p.inv_mult == 32'd0) begin
            p.status = ST_BAD;
        end else begin
            p.status = ST_OK;
        end
        return p;
    endfunction

    // Queue a prediction for each accepted word, then match each strobed result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                params_due.push_back(calc_params(i_clock_hz, i_span_seconds));
            end
            if (o_valid) begin
                if (params_due.size() == 0) begin
                    $error("result strobe with no word pending");
                    mismatch_count++;
                end else begin
                    due_word = params_due.pop_front();
                    if (o_fwd_mult !== due_word.fwd_mult) begin
                        $error("fwd_mult expected %0d actual %0d", due_word.fwd_mult, o_fwd_mult);
                        mismatch_count++;
                    end
                    if (o_fwd_shift !== due_word.fwd_shift) begin
                        $error("fwd_shift expected %0d actual %0d",
                               due_word.fwd_shift, o_fwd_shift);
                        mismatch_count++;
                    end
                    if (o_inv_mult !== due_word.inv_mult) begin
                        $error("inv_mult expected %0d actual %0d", due_word.inv_mult, o_inv_mult);
                        mismatch_count++;
                    end
                    if (o_inv_shift !== due_word.inv_shift) begin
                        $error("inv_shift expected %0d actual %0d",
                               due_word.inv_shift, o_inv_shift);
                        mismatch_count++;
                    end
                    if (o_status !== due_word.status) begin
                        $error("status expected %0d actual %0d", due_word.status, o_status);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL clock_mult_shift_calc_top");
            $finish;
        end
    end

    // Hold start high until the block takes the word; leave it high for a back-to-back word.
    task automatic send_word(input logic [63:0] hz, input logic [31:0] span);
        start          <= 1'b1;
        i_clock_hz     <= hz;
        i_span_seconds <= span;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic maybe_pause();
        int gap;
        gap = $urandom_range(1, 18);
        if (sender_pauses && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic test_zero_frequency();
        send_word(64'd0, 32'd1);
        maybe_pause();
        send_word(64'd0, 32'd0);
        send_word(64'd0, 32'hFFFF_FFFF);
        maybe_pause();
    endtask

    task automatic test_zero_span();
        send_word(64'd1, 32'd0);
        send_word(64'd24_000_000, 32'd0);
        maybe_pause();
        // span zero outranks a missing multiplier or inverse
        send_word((NS_PER_SEC << 32) + 64'd1, 32'd0);
        send_word(NS_PER_SEC << 32, 32'd0);
        maybe_pause();
    endtask

    task automatic test_field_extremes();
        send_word(64'd1, 32'hFFFF_FFFF);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 32'd1);
        maybe_pause();
        send_word(NS_PER_SEC, 32'd600);
        send_word(NS_PER_SEC - 64'd1, 32'd600);
        send_word(NS_PER_SEC + 64'd1, 32'd600);
        maybe_pause();
        send_word(64'hFFFF_FFFF, 32'h8000_0000);
        send_word(64'h8000_0000_0000_0000, 32'h7FFF_FFFF);
        maybe_pause();
    endtask

    task automatic test_multiplier_limits();
        // multiplier of one at the top shifts leaves no inverse
        send_word(NS_PER_SEC << 32, 32'd10);
        send_word(NS_PER_SEC << 31, 32'd10);
        send_word((NS_PER_SEC << 31) - 64'd1, 32'd10);
        maybe_pause();
        // just above the reachable range: no multiplier at all; at shift 30 a multiplier of one still has an inverse
        send_word((NS_PER_SEC << 32) + 64'd1, 32'd10);
        send_word(NS_PER_SEC << 30, 32'd10);
        maybe_pause();
        send_word(64'd3, 32'd1);
    endtask

    task automatic test_random_rates();
        logic [63:0] hz;
        logic [31:0] span;
        int          k;
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            sender_pauses = (i < RANDOM_WORDS - CALM_TAIL);
            case ($urandom_range(0, 3))
                0: hz = {$urandom(), $urandom()} >> $urandom_range(0, 63);
                1: hz = {32'd0, $urandom()};
                2: begin
                    // land near a shift boundary
                    k  = $urandom_range(0, 33);
                    hz = (NS_PER_SEC << k) + 64'($urandom_range(0, 6)) - 64'd3;
                end
                default: hz = 64'($urandom_range(1_000, 6_000_000)) * 64'd1000;
            endcase
            case ($urandom_range(0, 7))
                0:       span = 32'd0;
                1:       span = 32'hFFFF_FFFF;
                default: span = $urandom() >> $urandom_range(0, 31);
            endcase
            send_word(hz, span);
            maybe_pause();
        end
    endtask

    initial begin
        start          <= 1'b0;
        i_clock_hz     <= 64'd0;
        i_span_seconds <= 32'd0;
        i_rst_n        <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_frequency();
        test_zero_span();
        test_field_extremes();
        test_multiplier_limits();
        test_random_rates();

        start <= 1'b0;
        while (params_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("PASS clock_mult_shift_calc_top");
        end else begin
            $display("FAIL clock_mult_shift_calc_top");
        end
        $finish;
    end

endmodule

/* clock_mult_shift_calc_top.f */
rtl/cmsc_pkg.sv
rtl/cmsc_div.sv
rtl/clock_mult_shift_calc_top.sv
bench/clock_mult_shift_calc_top_test.sv
